// File: src/lkrm_pkg.sv
package lkrm_pkg;

  localparam int ID_SLOTS = 8;
  localparam int ID_BITS  = 3;

  // received item kinds
  localparam logic [3:0] K_REQ_DOCK    = 4'd0;
  localparam logic [3:0] K_REQ_MECH    = 4'd1;
  localparam logic [3:0] K_REL_DOCK    = 4'd2;
  localparam logic [3:0] K_REL_MECH    = 4'd3;
  localparam logic [3:0] K_REPLY_DOCK  = 4'd4;
  localparam logic [3:0] K_REPLY_MECH  = 4'd5;
  localparam logic [3:0] K_RETURN      = 4'd6;
  localparam logic [3:0] K_POLL        = 4'd7;
  localparam logic [3:0] K_REPAIR_DONE = 4'd8;
  localparam logic [3:0] K_IGNORED     = 4'd15;

  // outgoing message kinds
  localparam logic [2:0] M_NONE       = 3'd0;
  localparam logic [2:0] M_REPLY_DOCK = 3'd1;
  localparam logic [2:0] M_REPLY_MECH = 3'd2;
  localparam logic [2:0] M_REQ_DOCK   = 3'd3;
  localparam logic [2:0] M_REQ_MECH   = 3'd4;
  localparam logic [2:0] M_REL_DOCK   = 3'd5;
  localparam logic [2:0] M_REL_MECH   = 3'd6;

  // mode flag bits
  localparam int F_DOCK_REQ  = 0;
  localparam int F_IN_DOCK   = 1;
  localparam int F_WANT_MECH = 2;
  localparam int F_REPAIR    = 3;

  // register indexes
  localparam logic [1:0] R_OWN_ID     = 2'd0;
  localparam logic [1:0] R_NODE_COUNT = 2'd1;
  localparam logic [1:0] R_DOCK_COUNT = 2'd2;
  localparam logic [1:0] R_MECH_TOTAL = 2'd3;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  sender;
    logic [31:0] stamp;
    logic [7:0]  mechanics;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  msg_kind;
    logic [2:0]  dest;
    logic [31:0] out_stamp;
    logic [7:0]  out_mechanics;
    logic        docked;
    logic        repairing;
    logic        last;
  } out_item_t;

endpackage

// File: src/lamport_k_resource_mutex_node_unit.sv
// channel   | ports                                  | transfer
// ----------+----------------------------------------+-----------------------------------
// input     | start, busy, in_data                   | start high while busy low
// result    | out_strobe, out_data                   | single-cycle strobe per result, no stall
// config    | psel penable pwrite paddr pwdata       | access phase with pready high
//           | prdata pready                          | reads return register value
//
// an item takes a decode step, then one message per cycle within a broadcast; a
// broadcast sends up to 7 messages and a repair done sends a dock release broadcast
// then a mechanics release broadcast. a poll adds a table scan over the 8-entry
// request memory per resource checked (at most two). busy is high from the transfer until
// the final result is on the port. reset is synchronous, active low; the request
// tables come up empty through per-entry valid bits, no clearing pass. results
// cannot be stalled by the receiver.
module lamport_k_resource_mutex_node_unit
  import lkrm_pkg::*;
#(
  parameter int NODES      = 8,
  parameter int STAMP_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_strobe,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NODE_CAP = (NODES < ID_SLOTS) ? NODES : ID_SLOTS;
  localparam logic [3:0] NODE_CAP_V = 4'(NODE_CAP);
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};
  localparam int SB = STAMP_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t          state_r;
  in_item_t        item_r;
  logic [2:0]      own_id_r;
  logic [3:0]      node_count_r;
  logic [3:0]      dock_count_r;
  logic [7:0]      mech_total_r;

  logic [SB-1:0]   clock_r;
  logic [SB-1:0]   own_dock_stamp_r;
  logic [SB-1:0]   own_mech_stamp_r;
  logic [3:0]      flags_r;
  logic [7:0]      own_need_r;
  logic [3:0]      dock_reply_r;
  logic [3:0]      mech_reply_r;
  logic [7:0]      def_dock_r;
  logic [7:0]      def_mech_r;

  // emitter
  logic [7:0]      emask_r;
  logic [2:0]      ekind_r;
  logic            etick_r;
  logic [7:0]      emech_r;
  logic            second_r;

  // table scan
  logic [3:0]      scan_i_r;
  logic            pend_r;
  logic [2:0]      idx_r;
  logic            scan_mech_r;
  logic [3:0]      rank_r;
  logic [10:0]     used_r;
  logic            me_ok_r;

  out_item_t       out_r;
  logic            out_strobe_r;

  // table ports
  logic               dock_wr, dock_clr, mech_wr, mech_clr;
  logic [2:0]         dock_waddr, mech_waddr;
  logic [SB-1:0]      dock_wdata;
  logic [SB+7:0]      mech_wdata;
  logic               rd_en;
  logic               dock_rvalid, mech_rvalid;
  logic [SB-1:0]      dock_rdata;
  logic [SB+7:0]      mech_rdata;

  // decode helpers
  logic [3:0]      eff;
  logic [3:0]      needed;
  logic [7:0]      bcast;
  logic            bad;
  logic [3:0]      ex_kind;
  logic [SB-1:0]   st;
  logic [SB-1:0]   inc_clk;
  logic [SB-1:0]   merged;
  logic [7:0]      snd_bit;
  logic            dock_pre;
  logic            mech_pre;
  logic            scan_done;
  logic            dock_ok;
  logic            mech_ok;
  logic            sc_valid;
  logic [SB-1:0]   sc_stamp;
  logic [SB-1:0]   sc_own;
  logic            sc_prec;
  logic [2:0]      first_dest;
  logic [7:0]      rest_mask;

  function automatic logic [SB-1:0] sat_inc(input logic [SB-1:0] x);
    sat_inc = (x == STAMP_MAX) ? x : x + 1'b1;
  endfunction

  function automatic logic [2:0] lowest(input logic [7:0] m);
    logic [2:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) r = 3'(i);
    end
    lowest = r;
  endfunction

  always_comb begin
    eff    = (node_count_r > NODE_CAP_V) ? NODE_CAP_V : node_count_r;
    needed = (eff == 4'd0) ? 4'd0 : eff - 4'd1;
    for (int i = 0; i < ID_SLOTS; i++) begin
      bcast[i] = (4'(i) < eff) && (3'(i) != own_id_r);
    end
  end

  assign bad = (item_r.kind <= K_REPLY_MECH) &&
               ((item_r.sender == own_id_r) || ({1'b0, item_r.sender} >= eff));
  assign ex_kind = bad ? K_IGNORED : item_r.kind;
  assign st      = SB'(item_r.stamp);
  assign inc_clk = sat_inc(clock_r);
  assign merged  = sat_inc((st > clock_r) ? st : clock_r);
  assign snd_bit = 8'b1 << item_r.sender;

  assign dock_pre = flags_r[F_DOCK_REQ] && !flags_r[F_IN_DOCK] && (dock_reply_r >= needed);
  assign mech_pre = flags_r[F_IN_DOCK] && flags_r[F_WANT_MECH] && !flags_r[F_REPAIR] &&
                    (mech_reply_r >= needed);

  assign scan_done = (state_r == S_SCAN) && scan_i_r[3] && !pend_r;
  assign dock_ok   = me_ok_r && (rank_r < dock_count_r);
  assign mech_ok   = me_ok_r && ((used_r + 11'(own_need_r)) <= 11'(mech_total_r));

  // scanned entry against own request, ordered by stamp then id
  assign sc_valid = scan_mech_r ? mech_rvalid : dock_rvalid;
  assign sc_stamp = scan_mech_r ? mech_rdata[SB+7:8] : dock_rdata;
  assign sc_own   = scan_mech_r ? own_mech_stamp_r : own_dock_stamp_r;
  assign sc_prec  = (sc_stamp < sc_own) || ((sc_stamp == sc_own) && (idx_r < own_id_r));

  assign first_dest = lowest(emask_r);
  assign rest_mask  = emask_r & ~(8'b1 << first_dest);

  // table writes: remote requests and releases at decode, own entries on
  // return, repair done and dock admission
  always_comb begin
    dock_wr    = 1'b0;
    dock_clr   = 1'b0;
    dock_waddr = item_r.sender;
    dock_wdata = st;
    mech_wr    = 1'b0;
    mech_clr   = 1'b0;
    mech_waddr = item_r.sender;
    mech_wdata = {st, item_r.mechanics};
    if (state_r == S_EXEC) begin
      case (ex_kind)
        K_REQ_DOCK: dock_wr = 1'b1;
        K_REQ_MECH: mech_wr = 1'b1;
        K_REL_DOCK: dock_clr = 1'b1;
        K_REL_MECH: mech_clr = 1'b1;
        K_RETURN: begin
          dock_wr    = (flags_r == 4'd0);
          dock_waddr = own_id_r;
          dock_wdata = inc_clk;
        end
        K_REPAIR_DONE: begin
          dock_clr   = flags_r[F_REPAIR];
          mech_clr   = flags_r[F_REPAIR];
          dock_waddr = own_id_r;
          mech_waddr = own_id_r;
        end
        default: ;
      endcase
    end else if (scan_done && !scan_mech_r && dock_ok) begin
      mech_wr    = 1'b1;
      mech_waddr = own_id_r;
      mech_wdata = {inc_clk, own_need_r};
    end
  end

  assign rd_en = (state_r == S_SCAN) && !scan_i_r[3];

  lkrm_table #(.W(SB)) u_dock_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (dock_wr),
    .clr_en   (dock_clr),
    .wr_addr  (dock_waddr),
    .wr_data  (dock_wdata),
    .rd_en    (rd_en),
    .rd_addr  (scan_i_r[2:0]),
    .rd_valid (dock_rvalid),
    .rd_data  (dock_rdata)
  );

  lkrm_table #(.W(SB + 8)) u_mech_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (mech_wr),
    .clr_en   (mech_clr),
    .wr_addr  (mech_waddr),
    .wr_data  (mech_wdata),
    .rd_en    (rd_en),
    .rd_addr  (scan_i_r[2:0]),
    .rd_valid (mech_rvalid),
    .rd_data  (mech_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r     <= 3'd0;
      node_count_r <= 4'd8;
      dock_count_r <= 4'd4;
      mech_total_r <= 8'd20;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        R_OWN_ID:     own_id_r     <= pwdata[2:0];
        R_NODE_COUNT: node_count_r <= pwdata[3:0];
        R_DOCK_COUNT: dock_count_r <= pwdata[3:0];
        R_MECH_TOTAL: mech_total_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      R_OWN_ID:     prdata = {29'd0, own_id_r};
      R_NODE_COUNT: prdata = {28'd0, node_count_r};
      R_DOCK_COUNT: prdata = {28'd0, dock_count_r};
      R_MECH_TOTAL: prdata = {24'd0, mech_total_r};
      default:      prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (start && (state_r == S_IDLE)) begin
      item_r <= in_data;
    end
  end

  // sequencer: decode, optional admission scans, then message emission
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      clock_r          <= '0;
      own_dock_stamp_r <= '0;
      own_mech_stamp_r <= '0;
      flags_r          <= '0;
      own_need_r       <= '0;
      dock_reply_r     <= '0;
      mech_reply_r     <= '0;
      def_dock_r       <= '0;
      def_mech_r       <= '0;
      emask_r          <= '0;
      second_r         <= 1'b0;
      scan_i_r         <= '0;
      pend_r           <= 1'b0;
      out_strobe_r     <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) state_r <= S_EXEC;
        end

        S_EXEC: begin
          emask_r  <= '0;
          second_r <= 1'b0;
          etick_r  <= 1'b1;
          emech_r  <= '0;
          state_r  <= S_EMIT;
          case (ex_kind)
            K_REQ_DOCK: begin
              clock_r <= merged;
              ekind_r <= M_REPLY_DOCK;
              if (!flags_r[F_DOCK_REQ] || (st < own_dock_stamp_r) ||
                  ((st == own_dock_stamp_r) && (item_r.sender < own_id_r))) begin
                emask_r <= snd_bit;
              end else begin
                def_dock_r <= def_dock_r | snd_bit;
              end
            end
            K_REQ_MECH: begin
              clock_r <= merged;
              ekind_r <= M_REPLY_MECH;
              if (!flags_r[F_WANT_MECH] || (st < own_mech_stamp_r) ||
                  ((st == own_mech_stamp_r) && (item_r.sender < own_id_r))) begin
                emask_r <= snd_bit;
              end else begin
                def_mech_r <= def_mech_r | snd_bit;
              end
            end
            K_REL_DOCK: begin
              clock_r    <= merged;
              ekind_r    <= M_REPLY_DOCK;
              emask_r    <= def_dock_r;
              def_dock_r <= '0;
            end
            K_REL_MECH: begin
              clock_r    <= merged;
              ekind_r    <= M_REPLY_MECH;
              emask_r    <= def_mech_r;
              def_mech_r <= '0;
            end
            K_REPLY_DOCK: begin
              clock_r <= merged;
              if (dock_reply_r != 4'hf) dock_reply_r <= dock_reply_r + 4'd1;
            end
            K_REPLY_MECH: begin
              clock_r <= merged;
              if (mech_reply_r != 4'hf) mech_reply_r <= mech_reply_r + 4'd1;
            end
            K_RETURN: begin
              if (flags_r == 4'd0) begin
                own_need_r             <= item_r.mechanics;
                flags_r[F_DOCK_REQ]    <= 1'b1;
                own_dock_stamp_r       <= inc_clk;
                clock_r                <= inc_clk;
                dock_reply_r           <= '0;
                emask_r                <= bcast;
                ekind_r                <= M_REQ_DOCK;
                etick_r                <= 1'b0;
              end
            end
            K_POLL: begin
              scan_i_r <= '0;
              pend_r   <= 1'b0;
              rank_r   <= '0;
              used_r   <= '0;
              me_ok_r  <= 1'b0;
              if (dock_pre) begin
                scan_mech_r <= 1'b0;
                state_r     <= S_SCAN;
              end else if (mech_pre) begin
                scan_mech_r <= 1'b1;
                state_r     <= S_SCAN;
              end
            end
            K_REPAIR_DONE: begin
              if (flags_r[F_REPAIR]) begin
                flags_r  <= '0;
                clock_r  <= inc_clk;
                emask_r  <= bcast;
                ekind_r  <= M_REL_DOCK;
                etick_r  <= 1'b0;
                second_r <= 1'b1;
              end
            end
            default: ;
          endcase
        end

        S_SCAN: begin
          if (!scan_i_r[3]) scan_i_r <= scan_i_r + 4'd1;
          pend_r <= !scan_i_r[3];
          idx_r  <= scan_i_r[2:0];
          if (pend_r) begin
            if (idx_r == own_id_r) begin
              me_ok_r <= sc_valid && (sc_stamp == sc_own);
            end else if (sc_valid && sc_prec) begin
              rank_r <= rank_r + 4'd1;
              used_r <= used_r + 11'(mech_rdata[7:0]);
            end
          end
          if (scan_done) begin
            state_r <= S_EMIT;
            if (!scan_mech_r) begin
              if (dock_ok) begin
                flags_r[F_IN_DOCK]   <= 1'b1;
                flags_r[F_WANT_MECH] <= 1'b1;
                own_mech_stamp_r     <= inc_clk;
                clock_r              <= inc_clk;
                mech_reply_r         <= '0;
                emask_r              <= bcast;
                ekind_r              <= M_REQ_MECH;
                etick_r              <= 1'b0;
                emech_r              <= own_need_r;
                // with no replies needed the mechanics check follows at once
                if (needed == 4'd0) begin
                  state_r     <= S_SCAN;
                  scan_mech_r <= 1'b1;
                  scan_i_r    <= '0;
                  pend_r      <= 1'b0;
                  rank_r      <= '0;
                  used_r      <= '0;
                  me_ok_r     <= 1'b0;
                end
              end
            end else if (mech_ok) begin
              flags_r[F_REPAIR] <= 1'b1;
            end
          end
        end

        S_EMIT: begin
          if (emask_r != 8'd0) begin
            out_strobe_r          <= 1'b1;
            out_r.msg_kind        <= ekind_r;
            out_r.dest            <= first_dest;
            out_r.out_stamp       <= 32'(etick_r ? inc_clk : clock_r);
            out_r.out_mechanics   <= emech_r;
            out_r.docked          <= flags_r[F_IN_DOCK];
            out_r.repairing       <= flags_r[F_REPAIR];
            out_r.last            <= (rest_mask == 8'd0) && !second_r;
            if (etick_r) clock_r <= inc_clk;
            emask_r <= rest_mask;
            if ((rest_mask == 8'd0) && !second_r) state_r <= S_IDLE;
          end else if (second_r) begin
            // release of mechanics follows the dock release
            clock_r  <= inc_clk;
            emask_r  <= bcast;
            ekind_r  <= M_REL_MECH;
            second_r <= 1'b0;
          end else begin
            // nothing sent for this item: status only
            out_strobe_r        <= 1'b1;
            out_r.msg_kind      <= M_NONE;
            out_r.dest          <= '0;
            out_r.out_stamp     <= '0;
            out_r.out_mechanics <= '0;
            out_r.docked        <= flags_r[F_IN_DOCK];
            out_r.repairing     <= flags_r[F_REPAIR];
            out_r.last          <= 1'b1;
            state_r             <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  // repairing is only ever entered while a dock is held
  a_repair_in_dock: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r[F_REPAIR] |-> flags_r[F_IN_DOCK])
    else $error("repairing without a dock");

  // the final result of an item leaves the block ready for the next
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last) |-> !busy)
    else $error("busy after final result");

  // every result belongs to an item in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without an item");

  // an accepted item holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted but not busy");

endmodule

// File: src/lkrm_table.sv
module lkrm_table
  import lkrm_pkg::*;
#(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic               clr_en,
  input  logic [ID_BITS-1:0] wr_addr,
  input  logic [W-1:0]       wr_data,
  input  logic               rd_en,
  input  logic [ID_BITS-1:0] rd_addr,
  output logic               rd_valid,
  output logic [W-1:0]       rd_data
);

  logic [W-1:0]        mem [ID_SLOTS];
  logic [ID_SLOTS-1:0] valid_r;
  logic                rd_valid_r;
  logic [W-1:0]        rd_data_r;

  // per-entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end else if (clr_en) begin
      valid_r[wr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_data  = rd_data_r;

endmodule
